// ===== rtl/circle_pair_collision_response_defines.svh =====
// assertion macros for the collision response block
`ifndef CIRCLE_PAIR_COLLISION_RESPONSE_DEFINES_SVH
`define CIRCLE_PAIR_COLLISION_RESPONSE_DEFINES_SVH

`define CPC_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

`define CPC_ASSERT_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ===== rtl/cpcr_pkg.sv =====
package cpcr_pkg;
  localparam int POS_W = 21;
  localparam int VEL_W = 22;
  localparam int RAD_W = 16;
  localparam int CFG_W = 16;
  localparam int FRACTION_BITS_DEF = 8;
  localparam logic [CFG_W-1:0] RESTITUTION_RST = 16'd51118;
  localparam logic [CFG_W-1:0] PUSH_FRACTION_RST = 16'd13107;

  typedef enum logic [0:0] {
    REG_RESTITUTION = 1'b0,
    REG_PUSH_FRACTION = 1'b1
  } cfg_reg_t;
endpackage

// ===== rtl/circle_pair_collision_response.sv =====
// throughput: one pair per cycle; busy stays low, the pipeline never stalls
// square root and the two normal divisions are unrolled one bit per pipeline stage
// reset (rst_n low, synchronous) clears all valid bits and restores the two registers
// results are shown for one cycle with out_valid; the receiver cannot stall
`include "circle_pair_collision_response_defines.svh"
module circle_pair_collision_response import cpcr_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [POS_W-1:0] in_a_pos_x,
  input  logic signed [POS_W-1:0] in_a_pos_y,
  input  logic signed [VEL_W-1:0] in_a_vel_x,
  input  logic signed [VEL_W-1:0] in_a_vel_y,
  input  logic [RAD_W-1:0]        in_a_radius,
  input  logic signed [POS_W-1:0] in_b_pos_x,
  input  logic signed [POS_W-1:0] in_b_pos_y,
  input  logic signed [VEL_W-1:0] in_b_vel_x,
  input  logic signed [VEL_W-1:0] in_b_vel_y,
  input  logic [RAD_W-1:0]        in_b_radius,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [0:0]              cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  output logic                    out_valid,
  output logic signed [POS_W-1:0] out_new_a_pos_x,
  output logic signed [POS_W-1:0] out_new_a_pos_y,
  output logic signed [VEL_W-1:0] out_new_a_vel_x,
  output logic signed [VEL_W-1:0] out_new_a_vel_y,
  output logic signed [POS_W-1:0] out_new_b_pos_x,
  output logic signed [POS_W-1:0] out_new_b_pos_y,
  output logic signed [VEL_W-1:0] out_new_b_vel_x,
  output logic signed [VEL_W-1:0] out_new_b_vel_y,
  output logic                    out_resolved
);
  localparam int NF = FRACTION_BITS + 8;
  localparam int D_W = POS_W + 1;          // signed difference
  localparam int SQ_W = 2 * D_W;            // dx^2 + dy^2 (unsigned, max < 2^44)
  localparam int DIST_W = SQ_W / 2;         // sqrt result bits
  localparam int SQ_ST = DIST_W;            // sqrt stages
  localparam int QN_W = D_W + NF;           // |d|<<NF numerator magnitude bits
  localparam int DV_ST = QN_W;              // quotient bits (|n| <= 2^NF)
  localparam int N_W = NF + 2;              // signed normal
  localparam int RV_W = VEL_W + 1;
  localparam int SP_W = RV_W + N_W + 1;
  localparam int MG_W = VEL_W + 2;          // closing speed magnitude, below 2^23
  localparam int OV_W = DIST_W + 2;

  typedef struct packed {
    logic signed [POS_W-1:0] apx, apy, bpx, bpy;
    logic signed [VEL_W-1:0] avx, avy, bvx, bvy;
  } circ_t;

  logic [CFG_W-1:0] rest_r, push_r;
  assign cfg_ready = 1'b1;
  assign busy = 1'b0;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_r <= RESTITUTION_RST;
      push_r <= PUSH_FRACTION_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RESTITUTION:   rest_r <= cfg_data;
        REG_PUSH_FRACTION: push_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 0: differences
  logic s0_v_r;
  circ_t s0_c_r;
  logic signed [D_W-1:0] s0_dx_r, s0_dy_r;
  logic [RAD_W:0] s0_rad_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s0_v_r <= 1'b0;
    else s0_v_r <= start;
    s0_c_r <= '{in_a_pos_x, in_a_pos_y, in_b_pos_x, in_b_pos_y,
                in_a_vel_x, in_a_vel_y, in_b_vel_x, in_b_vel_y};
    s0_dx_r <= D_W'(in_a_pos_x) - D_W'(in_b_pos_x);
    s0_dy_r <= D_W'(in_a_pos_y) - D_W'(in_b_pos_y);
    s0_rad_r <= (RAD_W+1)'(in_a_radius) + (RAD_W+1)'(in_b_radius);
  end

  // stage 1: squares
  logic s1_v_r;
  circ_t s1_c_r;
  logic signed [D_W-1:0] s1_dx_r, s1_dy_r;
  logic [RAD_W:0] s1_rad_r;
  logic [SQ_W-1:0] s1_x2_r, s1_y2_r;
  logic [2*RAD_W+1:0] s1_r2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else s1_v_r <= s0_v_r;
    s1_c_r <= s0_c_r;
    s1_dx_r <= s0_dx_r;
    s1_dy_r <= s0_dy_r;
    s1_rad_r <= s0_rad_r;
    s1_x2_r <= SQ_W'(s0_dx_r) * SQ_W'(s0_dx_r);
    s1_y2_r <= SQ_W'(s0_dy_r) * SQ_W'(s0_dy_r);
    s1_r2_r <= (2*RAD_W+2)'(s0_rad_r) * (2*RAD_W+2)'(s0_rad_r);
  end

  // stage 2: sum and contact test
  logic s2_v_r, s2_hit_r;
  circ_t s2_c_r;
  logic signed [D_W-1:0] s2_dx_r, s2_dy_r;
  logic [RAD_W:0] s2_rad_r;
  logic [SQ_W-1:0] s2_dsq_r;
  logic [SQ_W-1:0] dsq_sum;
  assign dsq_sum = s1_x2_r + s1_y2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else s2_v_r <= s1_v_r;
    s2_c_r <= s1_c_r;
    s2_dx_r <= s1_dx_r;
    s2_dy_r <= s1_dy_r;
    s2_rad_r <= s1_rad_r;
    s2_dsq_r <= dsq_sum;
    s2_hit_r <= dsq_sum <= SQ_W'(s1_r2_r);
  end

  // square root pipeline, one result bit per stage
  typedef struct packed {
    logic v, hit;
    circ_t c;
    logic signed [D_W-1:0] dx, dy;
    logic [RAD_W:0] rad;
    logic [SQ_W-1:0] rem;
    logic [DIST_W-1:0] root;
  } sq_t;
  sq_t sq_r [SQ_ST+1];
  assign sq_r[0] = '{s2_v_r, s2_hit_r, s2_c_r, s2_dx_r, s2_dy_r, s2_rad_r, s2_dsq_r, '0};
  for (genvar g = 0; g < SQ_ST; g++) begin : g_sq
    localparam int B = SQ_ST - 1 - g;
    sq_t nx;
    logic [SQ_W+1:0] trial;
    always_comb begin
      nx = sq_r[g];
      trial = ((SQ_W+2)'(sq_r[g].root) << (B + 1)) + ((SQ_W+2)'(1) << (2 * B));
      if (trial <= (SQ_W+2)'(sq_r[g].rem)) begin
        nx.rem = sq_r[g].rem - SQ_W'(trial);
        nx.root[B] = 1'b1;
      end
    end
    sq_t q_r;
    always_ff @(posedge clk) begin
      if (!rst_n) q_r <= '0;
      else q_r <= nx;
    end
    assign sq_r[g+1] = q_r;
  end

  // divide stage setup
  typedef struct packed {
    logic v, hit, zero;
    circ_t c;
    logic [RAD_W:0] rad;
    logic [DIST_W-1:0] dlen;
    logic sx, sy;
    logic [QN_W-1:0] rx, ry, qx, qy;
  } dv_t;
  dv_t dv_r [DV_ST+1];
  sq_t sqo;
  logic [QN_W-1:0] ax, ay;
  assign sqo = sq_r[SQ_ST];
  assign ax = QN_W'(sqo.dx[D_W-1] ? -sqo.dx : sqo.dx);
  assign ay = QN_W'(sqo.dy[D_W-1] ? -sqo.dy : sqo.dy);
  assign dv_r[0] = '{sqo.v, sqo.hit, sqo.root == '0, sqo.c, sqo.rad, sqo.root,
                     sqo.dx[D_W-1], sqo.dy[D_W-1], '0, '0, ax << NF, ay << NF};
  // restoring division: q shifts numerator bits out, quotient bits in
  for (genvar g = 0; g < DV_ST; g++) begin : g_dv
    dv_t nx;
    logic [QN_W:0] tx, ty;
    always_comb begin
      nx = dv_r[g];
      tx = {dv_r[g].rx, dv_r[g].qx[QN_W-1]};
      ty = {dv_r[g].ry, dv_r[g].qy[QN_W-1]};
      nx.qx = {dv_r[g].qx[QN_W-2:0], 1'b0};
      nx.qy = {dv_r[g].qy[QN_W-2:0], 1'b0};
      if (tx >= (QN_W+1)'(dv_r[g].dlen)) begin
        nx.rx = QN_W'(tx - (QN_W+1)'(dv_r[g].dlen));
        nx.qx[0] = 1'b1;
      end else nx.rx = QN_W'(tx);
      if (ty >= (QN_W+1)'(dv_r[g].dlen)) begin
        nx.ry = QN_W'(ty - (QN_W+1)'(dv_r[g].dlen));
        nx.qy[0] = 1'b1;
      end else nx.ry = QN_W'(ty);
    end
    dv_t q_r;
    always_ff @(posedge clk) begin
      if (!rst_n) q_r <= '0;
      else q_r <= nx;
    end
    assign dv_r[g+1] = q_r;
  end

  // stage n: signed normal, relative velocity, overlap
  dv_t dvo;
  assign dvo = dv_r[DV_ST];
  logic n_v_r, n_hit_r;
  circ_t n_c_r;
  logic signed [N_W-1:0] n_x_r, n_y_r;
  logic signed [RV_W-1:0] n_rvx_r, n_rvy_r;
  logic signed [OV_W-1:0] n_ov_r;
  always_ff @(posedge clk) begin
    if (!rst_n) n_v_r <= 1'b0;
    else n_v_r <= dvo.v;
    n_hit_r <= dvo.hit;
    n_c_r <= dvo.c;
    if (dvo.zero) begin
      n_x_r <= N_W'(1) << NF;
      n_y_r <= '0;
      n_ov_r <= OV_W'(dvo.rad) - (OV_W'(1) << FRACTION_BITS);
    end else begin
      n_x_r <= dvo.sx ? -N_W'(dvo.qx) : N_W'(dvo.qx);
      n_y_r <= dvo.sy ? -N_W'(dvo.qy) : N_W'(dvo.qy);
      n_ov_r <= OV_W'(dvo.rad) - OV_W'(dvo.dlen);
    end
    n_rvx_r <= RV_W'(dvo.c.avx) - RV_W'(dvo.c.bvx);
    n_rvy_r <= RV_W'(dvo.c.avy) - RV_W'(dvo.c.bvy);
  end

  // stage p: dot product terms and push
  logic p_v_r, p_hit_r;
  circ_t p_c_r;
  logic signed [N_W-1:0] p_x_r, p_y_r;
  logic signed [SP_W-1:0] p_tx_r, p_ty_r;
  logic signed [OV_W+17:0] p_pp_r;
  always_ff @(posedge clk) begin
    if (!rst_n) p_v_r <= 1'b0;
    else p_v_r <= n_v_r;
    p_hit_r <= n_hit_r;
    p_c_r <= n_c_r;
    p_x_r <= n_x_r;
    p_y_r <= n_y_r;
    p_tx_r <= SP_W'(n_rvx_r) * SP_W'(n_x_r);
    p_ty_r <= SP_W'(n_rvy_r) * SP_W'(n_y_r);
    p_pp_r <= (OV_W+18)'(n_ov_r) * (OV_W+18)'($signed({1'b0, push_r}));
  end

  // stage s: speed, push truncated toward zero
  logic s_v_r, s_hit_r, s_go;
  circ_t s_c_r;
  logic signed [N_W-1:0] s_x_r, s_y_r;
  logic [MG_W-1:0] s_m_r;
  logic signed [OV_W+1:0] s_push_r;
  logic signed [SP_W-1:0] speed;
  assign speed = p_tx_r + p_ty_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s_v_r <= 1'b0;
    else s_v_r <= p_v_r;
    s_hit_r <= p_hit_r && (speed <= 0);
    s_c_r <= p_c_r;
    s_x_r <= p_x_r;
    s_y_r <= p_y_r;
    s_m_r <= MG_W'((-speed) >>> NF);
    s_push_r <= (OV_W+2)'((p_pp_r < 0 ? p_pp_r + (OV_W+18)'(65535) : p_pp_r) >>> 16);
  end
  assign s_go = s_hit_r;

  // stage k: impulse, 65536 + restitution is {1, restitution}
  logic k_v_r, k_hit_r;
  circ_t k_c_r;
  logic signed [N_W-1:0] k_x_r, k_y_r;
  logic [MG_W-1:0] k_k_r;
  logic signed [OV_W+1:0] k_push_r;
  logic [MG_W+16:0] k_prod;
  assign k_prod = (MG_W+17)'(s_m_r) * (MG_W+17)'({1'b1, rest_r});
  always_ff @(posedge clk) begin
    if (!rst_n) k_v_r <= 1'b0;
    else k_v_r <= s_v_r;
    k_hit_r <= s_go;
    k_c_r <= s_c_r;
    k_x_r <= s_x_r;
    k_y_r <= s_y_r;
    k_k_r <= k_prod[MG_W+16:17];
    k_push_r <= s_push_r;
  end

  // stage m: scale by normal
  localparam int M_W = OV_W + N_W + 2;
  logic m_v_r, m_hit_r;
  circ_t m_c_r;
  logic signed [M_W-1:0] m_vx_r, m_vy_r, m_px_r, m_py_r;
  always_ff @(posedge clk) begin
    if (!rst_n) m_v_r <= 1'b0;
    else m_v_r <= k_v_r;
    m_hit_r <= k_hit_r;
    m_c_r <= k_c_r;
    m_vx_r <= M_W'($signed({1'b0, k_k_r})) * M_W'(k_x_r);
    m_vy_r <= M_W'($signed({1'b0, k_k_r})) * M_W'(k_y_r);
    m_px_r <= M_W'(k_push_r) * M_W'(k_x_r);
    m_py_r <= M_W'(k_push_r) * M_W'(k_y_r);
  end

  function automatic logic signed [M_W-1:0] tz(input logic signed [M_W-1:0] v);
    logic signed [M_W-1:0] b;
    b = (M_W'(1) << NF) - M_W'(1);
    return (v < 0) ? (v + b) >>> NF : v >>> NF;
  endfunction
  function automatic logic signed [M_W-1:0] satw(input logic signed [M_W-1:0] v,
                                                 input int w);
    logic signed [M_W-1:0] hi;
    hi = (M_W'(1) << (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // stage o: add, saturate, output register
  logic o_v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) o_v_r <= 1'b0;
    else o_v_r <= m_v_r;
    out_resolved <= m_hit_r;
    if (m_hit_r) begin
      out_new_a_vel_x <= VEL_W'(satw(M_W'(m_c_r.avx) + tz(m_vx_r), VEL_W));
      out_new_a_vel_y <= VEL_W'(satw(M_W'(m_c_r.avy) + tz(m_vy_r), VEL_W));
      out_new_b_vel_x <= VEL_W'(satw(M_W'(m_c_r.bvx) - tz(m_vx_r), VEL_W));
      out_new_b_vel_y <= VEL_W'(satw(M_W'(m_c_r.bvy) - tz(m_vy_r), VEL_W));
      out_new_a_pos_x <= POS_W'(satw(M_W'(m_c_r.apx) + tz(m_px_r), POS_W));
      out_new_a_pos_y <= POS_W'(satw(M_W'(m_c_r.apy) + tz(m_py_r), POS_W));
      out_new_b_pos_x <= POS_W'(satw(M_W'(m_c_r.bpx) - tz(m_px_r), POS_W));
      out_new_b_pos_y <= POS_W'(satw(M_W'(m_c_r.bpy) - tz(m_py_r), POS_W));
    end else begin
      out_new_a_vel_x <= m_c_r.avx;
      out_new_a_vel_y <= m_c_r.avy;
      out_new_b_vel_x <= m_c_r.bvx;
      out_new_b_vel_y <= m_c_r.bvy;
      out_new_a_pos_x <= m_c_r.apx;
      out_new_a_pos_y <= m_c_r.apy;
      out_new_b_pos_x <= m_c_r.bpx;
      out_new_b_pos_y <= m_c_r.bpy;
    end
  end
  assign out_valid = o_v_r;

  `CPC_ASSERT_IMP(a_busy_low, clk, rst_n, 1'b1, !busy)
  `CPC_ASSERT_NXT(a_start_enters, clk, rst_n, start && !busy, s0_v_r)
  `CPC_ASSERT_NXT(a_out_follows, clk, rst_n, m_v_r, out_valid)
  `CPC_ASSERT_IMP(a_res_valid, clk, rst_n, out_resolved && out_valid, $past(m_hit_r))
endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
  import cpcr_pkg::*;

  localparam int NORM_SHIFT = FRACTION_BITS_DEF + 8;
  localparam int DRAIN_CYCLES = 150;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_PAIRS = 200;

  typedef struct {
    logic signed [POS_W-1:0] a_pos_x, a_pos_y, b_pos_x, b_pos_y;
    logic signed [VEL_W-1:0] a_vel_x, a_vel_y, b_vel_x, b_vel_y;
    logic [RAD_W-1:0]        a_radius, b_radius;
  } pair_t;

  typedef struct {
    logic signed [POS_W-1:0] a_pos_x, a_pos_y, b_pos_x, b_pos_y;
    logic signed [VEL_W-1:0] a_vel_x, a_vel_y, b_vel_x, b_vel_y;
    logic                    resolved;
  } response_t;

  class collision_scoreboard;
    logic [CFG_W-1:0] restitution;
    logic [CFG_W-1:0] push_fraction;
    response_t pending[$];
    int errors;
    int pairs_seen;
    int hits_seen;

    function new();
      restitution = RESTITUTION_RST;
      push_fraction = PUSH_FRACTION_RST;
      errors = 0;
      pairs_seen = 0;
      hits_seen = 0;
    endfunction

    function longint unsigned root_floor(longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function longint clamp(longint v, int w);
      longint hi;
      hi = (longint'(1) << (w - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function longint along_normal(longint v, longint n);
      return (v * n) / (longint'(1) << NORM_SHIFT);
    endfunction

    function response_t respond(pair_t p);
      response_t r;
      longint apx, apy, avx, avy, bpx, bpy, bvx, bvy, rad;
      longint dx, dy, dsq, dlen, nx, ny, closing, k, dvx, dvy, overlap, push, dpx, dpy;
      longint unsigned m;
      apx = longint'(p.a_pos_x); apy = longint'(p.a_pos_y);
      avx = longint'(p.a_vel_x); avy = longint'(p.a_vel_y);
      bpx = longint'(p.b_pos_x); bpy = longint'(p.b_pos_y);
      bvx = longint'(p.b_vel_x); bvy = longint'(p.b_vel_y);
      rad = longint'(p.a_radius) + longint'(p.b_radius);
      r.a_pos_x = p.a_pos_x; r.a_pos_y = p.a_pos_y;
      r.a_vel_x = p.a_vel_x; r.a_vel_y = p.a_vel_y;
      r.b_pos_x = p.b_pos_x; r.b_pos_y = p.b_pos_y;
      r.b_vel_x = p.b_vel_x; r.b_vel_y = p.b_vel_y;
      r.resolved = 1'b0;
      dx = apx - bpx;
      dy = apy - bpy;
      dsq = dx * dx + dy * dy;
      if (dsq <= rad * rad) begin
        dlen = longint'(root_floor(dsq));
        if (dlen == 0) begin
          // coincident centers: fixed normal along x
          nx = longint'(1) << NORM_SHIFT;
          ny = 0;
          dlen = longint'(1) << FRACTION_BITS_DEF;
        end else begin
          nx = (dx * (longint'(1) << NORM_SHIFT)) / dlen;
          ny = (dy * (longint'(1) << NORM_SHIFT)) / dlen;
        end
        closing = (avx - bvx) * nx + (avy - bvy) * ny;
        if (closing <= 0) begin
          m = longint'(-closing) >> NORM_SHIFT;
          k = longint'((m * (64'd65536 + restitution)) >> 17);
          dvx = along_normal(k, nx);
          dvy = along_normal(k, ny);
          overlap = rad - dlen;
          push = (overlap * longint'(push_fraction)) / 65536;
          dpx = along_normal(push, nx);
          dpy = along_normal(push, ny);
          r.a_vel_x = VEL_W'(clamp(avx + dvx, VEL_W));
          r.a_vel_y = VEL_W'(clamp(avy + dvy, VEL_W));
          r.b_vel_x = VEL_W'(clamp(bvx - dvx, VEL_W));
          r.b_vel_y = VEL_W'(clamp(bvy - dvy, VEL_W));
          r.a_pos_x = POS_W'(clamp(apx + dpx, POS_W));
          r.a_pos_y = POS_W'(clamp(apy + dpy, POS_W));
          r.b_pos_x = POS_W'(clamp(bpx - dpx, POS_W));
          r.b_pos_y = POS_W'(clamp(bpy - dpy, POS_W));
          r.resolved = 1'b1;
        end
      end
      return r;
    endfunction

    function void note_pair(pair_t p);
      response_t r;
      r = respond(p);
      pending.push_back(r);
      pairs_seen++;
      if (r.resolved) hits_seen++;
    endfunction

    function void compare(string field, longint want, longint got);
      if (want != got) begin
        $display("%0t mismatch %s: expected %0d actual %0d", $realtime, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(response_t got);
      response_t want;
      if (pending.size() == 0) begin
        $display("%0t unexpected word: no response pending", $realtime);
        errors++;
        return;
      end
      want = pending.pop_front();
      compare("new_a_pos_x", longint'(want.a_pos_x), longint'(got.a_pos_x));
      compare("new_a_pos_y", longint'(want.a_pos_y), longint'(got.a_pos_y));
      compare("new_a_vel_x", longint'(want.a_vel_x), longint'(got.a_vel_x));
      compare("new_a_vel_y", longint'(want.a_vel_y), longint'(got.a_vel_y));
      compare("new_b_pos_x", longint'(want.b_pos_x), longint'(got.b_pos_x));
      compare("new_b_pos_y", longint'(want.b_pos_y), longint'(got.b_pos_y));
      compare("new_b_vel_x", longint'(want.b_vel_x), longint'(got.b_vel_x));
      compare("new_b_vel_y", longint'(want.b_vel_y), longint'(got.b_vel_y));
      compare("resolved", longint'(want.resolved), longint'(got.resolved));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [POS_W-1:0] in_a_pos_x, in_a_pos_y, in_b_pos_x, in_b_pos_y;
  logic signed [VEL_W-1:0] in_a_vel_x, in_a_vel_y, in_b_vel_x, in_b_vel_y;
  logic [RAD_W-1:0] in_a_radius, in_b_radius;
  logic cfg_valid;
  logic cfg_ready;
  logic [0:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic out_valid;
  logic signed [POS_W-1:0] out_new_a_pos_x, out_new_a_pos_y, out_new_b_pos_x, out_new_b_pos_y;
  logic signed [VEL_W-1:0] out_new_a_vel_x, out_new_a_vel_y, out_new_b_vel_x, out_new_b_vel_y;
  logic out_resolved;

  collision_scoreboard board;
  int cycles = 0;
  int settings_used;

  circle_pair_collision_response DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_a_pos_x(in_a_pos_x), .in_a_pos_y(in_a_pos_y),
    .in_a_vel_x(in_a_vel_x), .in_a_vel_y(in_a_vel_y), .in_a_radius(in_a_radius),
    .in_b_pos_x(in_b_pos_x), .in_b_pos_y(in_b_pos_y),
    .in_b_vel_x(in_b_vel_x), .in_b_vel_y(in_b_vel_y), .in_b_radius(in_b_radius),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid),
    .out_new_a_pos_x(out_new_a_pos_x), .out_new_a_pos_y(out_new_a_pos_y),
    .out_new_a_vel_x(out_new_a_vel_x), .out_new_a_vel_y(out_new_a_vel_y),
    .out_new_b_pos_x(out_new_b_pos_x), .out_new_b_pos_y(out_new_b_pos_y),
    .out_new_b_vel_x(out_new_b_vel_x), .out_new_b_vel_y(out_new_b_vel_y),
    .out_resolved(out_resolved)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    pair_t seen;
    response_t got;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles", $realtime, cycles);
      $display("tb: failure");
      $finish;
    end
    if (rst_n) begin
      if (start && !busy) begin
        seen.a_pos_x = in_a_pos_x; seen.a_pos_y = in_a_pos_y;
        seen.a_vel_x = in_a_vel_x; seen.a_vel_y = in_a_vel_y;
        seen.b_pos_x = in_b_pos_x; seen.b_pos_y = in_b_pos_y;
        seen.b_vel_x = in_b_vel_x; seen.b_vel_y = in_b_vel_y;
        seen.a_radius = in_a_radius; seen.b_radius = in_b_radius;
        board.note_pair(seen);
      end
      if (out_valid) begin
        got.a_pos_x = out_new_a_pos_x; got.a_pos_y = out_new_a_pos_y;
        got.a_vel_x = out_new_a_vel_x; got.a_vel_y = out_new_a_vel_y;
        got.b_pos_x = out_new_b_pos_x; got.b_pos_y = out_new_b_pos_y;
        got.b_vel_x = out_new_b_vel_x; got.b_vel_y = out_new_b_vel_y;
        got.resolved = out_resolved;
        board.check_result(got);
      end
    end
  end

  function automatic longint rand_signed(int w);
    logic [63:0] v;
    v = {$urandom, $urandom};
    return $signed(v << (64 - w)) >>> (64 - w);
  endfunction

  function automatic longint rand_vel();
    return rand_signed(VEL_W) >>> $urandom_range(0, VEL_W - 2);
  endfunction

  function automatic bit pos_ok(longint v);
    return v >= -(longint'(1) << (POS_W - 1)) && v < (longint'(1) << (POS_W - 1));
  endfunction

  function automatic pair_t make_pair(longint ax, longint ay, longint avx, longint avy,
                                      int ar, longint bx, longint by, longint bvx,
                                      longint bvy, int br);
    pair_t p;
    p.a_pos_x = POS_W'(ax); p.a_pos_y = POS_W'(ay);
    p.a_vel_x = VEL_W'(avx); p.a_vel_y = VEL_W'(avy); p.a_radius = RAD_W'(ar);
    p.b_pos_x = POS_W'(bx); p.b_pos_y = POS_W'(by);
    p.b_vel_x = VEL_W'(bvx); p.b_vel_y = VEL_W'(bvy); p.b_radius = RAD_W'(br);
    return p;
  endfunction

  // mostly pairs that touch or overlap, some full-range noise
  function automatic pair_t random_pair();
    longint ax, ay, ox, oy, bx, by;
    int ar, br, rsum;
    if ($urandom_range(0, 4) == 0)
      return make_pair(rand_signed(POS_W), rand_signed(POS_W), rand_signed(VEL_W),
                       rand_signed(VEL_W), $urandom_range(0, 65535), rand_signed(POS_W),
                       rand_signed(POS_W), rand_signed(VEL_W), rand_signed(VEL_W),
                       $urandom_range(0, 65535));
    ar = $urandom_range(0, 2) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 3000);
    br = $urandom_range(0, 2) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 3000);
    rsum = ar + br;
    ax = rand_signed(POS_W);
    ay = rand_signed(POS_W);
    if ($urandom_range(0, 7) == 0)
      ax = ax < 0 ? -(longint'(1) << 20) + longint'($urandom_range(0, 300))
                  : (longint'(1) << 20) - 1 - longint'($urandom_range(0, 300));
    if ($urandom_range(0, 15) == 0) begin
      ox = 0;
      oy = 0;
    end else begin
      ox = longint'($urandom_range(0, 2 * rsum)) - rsum;
      oy = longint'($urandom_range(0, 2 * rsum)) - rsum;
    end
    bx = pos_ok(ax - ox) ? ax - ox : ax + ox;
    by = pos_ok(ay - oy) ? ay - oy : ay + oy;
    return make_pair(ax, ay, rand_vel(), rand_vel(), ar, bx, by, rand_vel(), rand_vel(), br);
  endfunction

  task automatic send_pair(pair_t p);
    @(negedge clk);
    in_a_pos_x = p.a_pos_x; in_a_pos_y = p.a_pos_y;
    in_a_vel_x = p.a_vel_x; in_a_vel_y = p.a_vel_y; in_a_radius = p.a_radius;
    in_b_pos_x = p.b_pos_x; in_b_pos_y = p.b_pos_y;
    in_b_vel_x = p.b_vel_x; in_b_vel_y = p.b_vel_y; in_b_radius = p.b_radius;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause_sender(int n);
    @(negedge clk);
    start = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic run_random(int count);
    int left, burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8);
      if (burst > left) burst = left;
      repeat (burst) send_pair(random_pair());
      left -= burst;
      pause_sender($urandom_range(1, 6));
    end
  endtask

  task automatic drain();
    pause_sender(1);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_index = idx;
    cfg_data = value;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_RESTITUTION) board.restitution = value;
    else board.push_fraction = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic new_setting(logic [CFG_W-1:0] rest, logic [CFG_W-1:0] push);
    drain();
    write_reg(REG_RESTITUTION, rest);
    write_reg(REG_PUSH_FRACTION, push);
    settings_used++;
  endtask

  initial begin
    board = new();
    settings_used = 1;
    rst_n = 1'b0;
    start = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_RESTITUTION;
    cfg_data = '0;
    in_a_pos_x = '0; in_a_pos_y = '0; in_a_vel_x = '0; in_a_vel_y = '0; in_a_radius = '0;
    in_b_pos_x = '0; in_b_pos_y = '0; in_b_vel_x = '0; in_b_vel_y = '0; in_b_radius = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed pairs at reset settings
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(make_pair(500, -700, 1000, 0, 65535, 500, -700, -1000, 0, 65535));
    send_pair(make_pair(0, 0, 0, 0, 10, 100, 0, 0, 0, 10));
    send_pair(make_pair(-(1 << 20), -(1 << 20), 0, 0, 65535, (1 << 20) - 1, (1 << 20) - 1,
                        0, 0, 65535));
    send_pair(make_pair(0, 0, 5000, 0, 1000, 2000, 0, -5000, 0, 1000));
    send_pair(make_pair(0, 0, -5000, 0, 1000, 2000, 0, 5000, 0, 1000));
    send_pair(make_pair(0, 0, 300, -40, 1000, 1500, 800, 300, -40, 1000));
    send_pair(make_pair((1 << 20) - 1, 0, (1 << 21) - 1, 0, 65535, (1 << 20) - 20, 0,
                        -(1 << 21), 0, 65535));
    send_pair(make_pair(-(1 << 20), 5, -(1 << 21), -(1 << 21), 65535, -(1 << 20) + 30, 0,
                        (1 << 21) - 1, (1 << 21) - 1, 65535));
    send_pair(make_pair(0, (1 << 20) - 1, 0, (1 << 21) - 1, 65535, 3, (1 << 20) - 40,
                        0, -(1 << 21), 65535));
    send_pair(make_pair(0, -(1 << 20), 0, -(1 << 21), 40000, 7, -(1 << 20) + 50,
                        0, (1 << 21) - 1, 40000));
    send_pair(make_pair(-1, -1, -1, -1, 65535, -1, -1, -1, -1, 65535));
    send_pair(make_pair(100, 100, 0, 0, 3, 100, 100, 0, 0, 4));
    send_pair(make_pair(0, 0, 2000, 2000, 700, 900, 900, -2000, -2000, 700));
    send_pair(make_pair(0, 0, 0, 0, 32768, 0, 65535, 0, 0, 32768));
    pause_sender(3);
    run_random(PHASE_PAIRS);

    new_setting(16'd0, 16'd0);
    run_random(PHASE_PAIRS);
    new_setting(16'hFFFF, 16'hFFFF);
    run_random(PHASE_PAIRS);
    new_setting(CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(0, 65535)));
    run_random(PHASE_PAIRS);
    new_setting(16'hFFFF, 16'd0);
    send_pair(make_pair(0, 0, 5000, 0, 1000, 2000, 0, -5000, 0, 1000));
    run_random(PHASE_PAIRS / 2);
    new_setting(16'd0, 16'hFFFF);
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    run_random(PHASE_PAIRS / 2);
    drain();

    $display("covered %0d pairs (%0d resolved) over %0d register settings",
             board.pairs_seen, board.hits_seen, settings_used);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d errors, %0d responses missing", board.errors, board.pending.size());
      $display("tb: failure");
    end
    $finish;
  end
endmodule
